>>> hdl/ptw_pkg.sv
// shared types, codes and helpers for the page table walker
// no dependencies; used by every module under hdl
package ptw_pkg;

  localparam int MAX_LEVELS       = 4;
  localparam int PAGE_OFFSET_BITS = 12;
  localparam int VADDR_W          = 50;
  localparam int PTE_W            = 64;
  localparam int PADDR_W          = 56;
  localparam int PPN_W            = 44;
  localparam int MODE_W           = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 44;

  localparam logic [MODE_W-1:0] MODE_BARE = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SV39 = 4'd8;
  localparam logic [MODE_W-1:0] MODE_SV48 = 4'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GUEST = 2'd2;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_PTE_RESP  = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_W_NO_R     = 3'd2,
    ST_NONLEAF_AD = 3'd3,
    ST_NO_LEVELS  = 3'd4,
    ST_BAD_MODE   = 3'd5
  } status_t;

  typedef struct packed {
    logic               op;
    logic [VADDR_W-1:0] vaddr;
    logic [PTE_W-1:0]   pte_data;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [PADDR_W-1:0] address;
    logic [2:0]         level;
    status_t            status;
    logic [1:0]         pbmt;
  } result_t;

  // number of levels for a mode, zero when unsupported
  function automatic logic [2:0] mode_levels(logic [MODE_W-1:0] mode);
    logic [2:0] lv;
    lv = 3'd0;
    if (mode == MODE_SV39) begin
      lv = 3'd3;
    end else if (mode == MODE_SV48) begin
      lv = (MAX_LEVELS >= 4) ? 3'd4 : 3'd0;
    end
    return lv;
  endfunction

  // byte offset of the pte inside its table: vpn slice times eight
  // idx counts 9-bit slices above the page offset
  function automatic logic [13:0] pte_offset(logic [VADDR_W-1:0] va, logic [1:0] idx,
                                             logic wide);
    logic [VADDR_W-1:0] sh;
    logic [10:0]        vpn;
    case (idx)
      2'd0:    sh = va >> 12;
      2'd1:    sh = va >> 21;
      2'd2:    sh = va >> 30;
      default: sh = va >> 39;
    endcase
    vpn = wide ? sh[10:0] : {2'b00, sh[8:0]};
    return {vpn, 3'b000};
  endfunction

endpackage

>>> hdl/ptw_in_stage.sv
// input register of the page table walker
// depends on ptw_pkg
module ptw_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ptw_pkg::item_t  in_item,
  input  logic            advance,
  output logic            item_valid,
  output ptw_pkg::item_t  item
);

  logic           valid_r, valid_nxt;
  ptw_pkg::item_t item_r;
  logic           load;

  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> hdl/ptw_core.sv
// walk state, configuration registers and the per-word pte check
// depends on ptw_pkg
module ptw_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ptw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             fire,
  input  ptw_pkg::item_t                   item,
  output logic                             has_result,
  output ptw_pkg::result_t                 result,
  output logic                             walk_active
);

  logic [ptw_pkg::MODE_W-1:0]  mode_r;
  logic [ptw_pkg::PPN_W-1:0]   root_r;
  logic                        guest_r;

  logic                        active_r, active_nxt;
  logic [1:0]                  level_r, level_nxt;
  logic [ptw_pkg::PADDR_W-1:0] base_r, base_nxt;
  logic [ptw_pkg::VADDR_W-1:0] va_r, va_nxt;

  logic [2:0]                  levels;
  logic [2:0]                  lvl_m1;
  logic [2:0]                  traversed;
  logic [2:0]                  rem_idx;
  logic [2:0]                  xwr;
  logic [ptw_pkg::PADDR_W-1:0] root_base;
  logic [ptw_pkg::PADDR_W-1:0] next_base;
  logic [13:0]                 req_off;
  logic [13:0]                 walk_off;
  ptw_pkg::result_t            res;
  logic                        has;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ptw_pkg::MODE_BARE;
      root_r  <= '0;
      guest_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptw_pkg::CFG_MODE:  mode_r  <= cfg_wdata[ptw_pkg::MODE_W-1:0];
        ptw_pkg::CFG_ROOT:  root_r  <= cfg_wdata[ptw_pkg::PPN_W-1:0];
        ptw_pkg::CFG_GUEST: guest_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign levels    = ptw_pkg::mode_levels(mode_r);
  assign lvl_m1    = levels - 3'd1;
  assign traversed = {1'b0, level_r} + 3'd1;
  assign rem_idx   = lvl_m1 - traversed;
  assign xwr       = item.pte_data[3:1];
  assign root_base = {root_r, {ptw_pkg::PAGE_OFFSET_BITS{1'b0}}};
  assign next_base = {item.pte_data[53:10], {ptw_pkg::PAGE_OFFSET_BITS{1'b0}}};

  // the new walk reads from the top slice, which is wider in guest layouts
  assign req_off  = ptw_pkg::pte_offset(item.vaddr, lvl_m1[1:0], guest_r);
  assign walk_off = ptw_pkg::pte_offset(va_r, rem_idx[1:0], 1'b0);

  always_comb begin
    active_nxt  = active_r;
    level_nxt   = level_r;
    base_nxt    = base_r;
    va_nxt      = va_r;
    has         = 1'b1;
    res.kind    = ptw_pkg::KIND_DONE;
    res.address = '0;
    res.level   = 3'd0;
    res.status  = ptw_pkg::ST_OK;
    res.pbmt    = 2'b00;
    if (item.op == ptw_pkg::OP_TRANSLATE) begin
      if (mode_r == ptw_pkg::MODE_BARE) begin
        active_nxt  = 1'b0;
        res.address = {{(ptw_pkg::PADDR_W-ptw_pkg::VADDR_W){1'b0}}, item.vaddr};
      end else if (levels == 3'd0) begin
        active_nxt = 1'b0;
        res.status = ptw_pkg::ST_BAD_MODE;
      end else begin
        active_nxt  = 1'b1;
        level_nxt   = 2'd0;
        va_nxt      = item.vaddr;
        base_nxt    = root_base;
        res.kind    = ptw_pkg::KIND_READ;
        res.address = root_base + {{(ptw_pkg::PADDR_W-14){1'b0}}, req_off};
      end
    end else if (!active_r) begin
      has = 1'b0;
    end else begin
      res.level = traversed;
      if (levels == 3'd0) begin
        active_nxt = 1'b0;
        res.status = ptw_pkg::ST_BAD_MODE;
      end else if (!item.pte_data[0]) begin
        active_nxt = 1'b0;
        res.status = ptw_pkg::ST_INVALID;
      end else if (xwr[1:0] == 2'b10) begin
        active_nxt = 1'b0;
        res.status = ptw_pkg::ST_W_NO_R;
      end else if (xwr != 3'b000) begin
        // leaf: ppn with the page offset, no superpage merging
        active_nxt  = 1'b0;
        res.address = {item.pte_data[53:10], va_r[ptw_pkg::PAGE_OFFSET_BITS-1:0]};
        res.pbmt    = item.pte_data[62:61];
      end else if (item.pte_data[7:6] != 2'b00) begin
        active_nxt = 1'b0;
        res.status = ptw_pkg::ST_NONLEAF_AD;
      end else if (traversed >= levels) begin
        active_nxt = 1'b0;
        res.status = ptw_pkg::ST_NO_LEVELS;
      end else begin
        level_nxt   = traversed[1:0];
        base_nxt    = next_base;
        res.kind    = ptw_pkg::KIND_READ;
        res.address = next_base + {{(ptw_pkg::PADDR_W-14){1'b0}}, walk_off};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      level_r  <= 2'd0;
      base_r   <= '0;
      va_r     <= '0;
    end else if (fire) begin
      active_r <= active_nxt;
      level_r  <= level_nxt;
      base_r   <= base_nxt;
      va_r     <= va_nxt;
    end
  end

  assign has_result  = has;
  assign result      = res;
  assign walk_active = active_r;

endmodule

>>> hdl/ptw_out_stage.sv
// result register of the page table walker
// depends on ptw_pkg
module ptw_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ptw_pkg::result_t  result,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output ptw_pkg::result_t  out_result
);

  logic             valid_r, valid_nxt;
  ptw_pkg::result_t result_r;

  assign room      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (out_stall ? valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

>>> hdl/page_table_walker.sv
// Page table walker for Sv39 and Sv48 and their x4 guest-stage layouts. A
// translate word either finishes at once (bare or unsupported mode) or
// starts a walk and yields the first PTE read address; each PTE response
// word yields the next read address or the finished result with status,
// level count and PBMT. Every word passes an input register and one stage
// of check and address logic into a result register, so one word is taken
// per clock while the receiver does not stall. A word leaves the input
// register and its result is loaded into the result register once that
// register has room. A PTE response while no walk is active is dropped
// without a result. An open walk uses the live configuration on each
// response. Write configuration only while no word is in flight.
// depends on ptw_pkg, ptw_in_stage, ptw_core, ptw_out_stage
module page_table_walker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ptw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [ptw_pkg::VADDR_W-1:0]      in_vaddr,
  input  logic [ptw_pkg::PTE_W-1:0]        in_pte_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_kind,
  output logic [ptw_pkg::PADDR_W-1:0]      out_address,
  output logic [2:0]                       out_level,
  output logic [2:0]                       out_status,
  output logic [1:0]                       out_pbmt
);

  ptw_pkg::item_t   in_item;
  ptw_pkg::item_t   item;
  ptw_pkg::result_t result;
  ptw_pkg::result_t out_result;
  logic             item_valid;
  logic             room;
  logic             fire;
  logic             has_result;
  logic             walk_active;

  assign in_item.op       = in_op;
  assign in_item.vaddr    = in_vaddr;
  assign in_item.pte_data = in_pte_data;

  assign fire = item_valid && room;

  ptw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  ptw_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fire        (fire),
    .item        (item),
    .has_result  (has_result),
    .result      (result),
    .walk_active (walk_active)
  );

  ptw_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && has_result),
    .result     (result),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_kind    = out_result.kind;
  assign out_address = out_result.address;
  assign out_level   = out_result.level;
  assign out_status  = out_result.status;
  assign out_pbmt    = out_result.pbmt;

  // read requests never carry a status or memory type
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ptw_pkg::KIND_READ |->
      out_status == ptw_pkg::ST_OK && out_pbmt == 2'b00)
    else $error("read request with status or pbmt set");

  // a failed walk reports no address
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ptw_pkg::KIND_DONE && out_status != ptw_pkg::ST_OK |->
      out_address == '0)
    else $error("error result with nonzero address");

  // a finished result closes the walk, a read keeps it open
  a_walk_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && has_result |=> walk_active == !$past(result.kind))
    else $error("walk state disagrees with last result kind");

endmodule

>>> tb/ptw_checker.sv
// checker for the page table walker: watches the config port and both channels,
// predicts every result word from its own copy of the walk state and compares
// depends on ptw_pkg for field widths, codes and the result struct
`timescale 1ns / 100ps

module ptw_checker import ptw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_op,
  input  logic [VADDR_W-1:0]    in_vaddr,
  input  logic [PTE_W-1:0]      in_pte_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_kind,
  input  logic [PADDR_W-1:0]    out_address,
  input  logic [2:0]            out_level,
  input  logic [2:0]            out_status,
  input  logic [1:0]            out_pbmt,
  output int                    mismatches,
  output int                    pending,
  output int                    predicted
);

  logic [MODE_W-1:0]  mode_r;
  logic [PPN_W-1:0]   root_r;
  logic               guest_r;

  logic               walking;
  logic [1:0]         depth;
  logic [PADDR_W-1:0] base;
  logic [VADDR_W-1:0] va_held;

  result_t            walk_results_q[$];
  int                 n_fail;
  int                 n_pred;

  function automatic result_t finished(logic [PADDR_W-1:0] addr, logic [2:0] lvl,
                                       status_t st, logic [1:0] pbmt);
    result_t r;
    r.kind    = KIND_DONE;
    r.address = addr;
    r.level   = lvl;
    r.status  = st;
    r.pbmt    = pbmt;
    return r;
  endfunction

  // pte address for the current depth: vpn slice scaled by eight on the table base
  function automatic result_t read_request(logic [2:0] levels);
    result_t            r;
    int unsigned        lo;
    logic [VADDR_W-1:0] sh;
    logic [10:0]        vpn;
    lo  = 12 + 9 * (levels - 1 - depth);
    sh  = va_held >> lo;
    vpn = sh[10:0];
    // only the root level of the x4 layouts has the two extra vpn bits
    if (depth != 2'd0 || !guest_r) begin
      vpn[10:9] = 2'b00;
    end
    r.kind    = KIND_READ;
    r.address = base + {vpn, 3'b000};
    r.level   = {1'b0, depth};
    r.status  = ST_OK;
    r.pbmt    = 2'b00;
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      n_fail++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    result_t            want;
    logic [2:0]         levels;
    logic [2:0]         traversed;
    logic [2:0]         xwr;
    logic [PADDR_W-1:0] next_base;
    if (!rst_n) begin
      mode_r  = MODE_BARE;
      root_r  = '0;
      guest_r = 1'b0;
      walking = 1'b0;
      depth   = 2'd0;
      base    = '0;
      va_held = '0;
      walk_results_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (walk_results_q.size() == 0) begin
          n_fail++;
          $error("result word with nothing expected: kind %0d address 0x%0h status %0d",
                 out_kind, out_address, out_status);
        end else begin
          want = walk_results_q.pop_front();
          compare_field("kind", 64'(want.kind), 64'(out_kind));
          compare_field("address", 64'(want.address), 64'(out_address));
          compare_field("level", 64'(want.level), 64'(out_level));
          compare_field("status", 64'(want.status), 64'(out_status));
          compare_field("pbmt", 64'(want.pbmt), 64'(out_pbmt));
        end
      end

      if (in_valid && !in_stall) begin
        case (mode_r)
          MODE_SV39: levels = 3'd3;
          MODE_SV48: levels = 3'd4;
          default:   levels = 3'd0;
        endcase
        if (in_op == OP_TRANSLATE) begin
          walking = 1'b0;
          if (mode_r == MODE_BARE) begin
            walk_results_q.push_back(finished(PADDR_W'(in_vaddr), 3'd0, ST_OK, 2'b00));
          end else if (levels == 3'd0) begin
            walk_results_q.push_back(finished('0, 3'd0, ST_BAD_MODE, 2'b00));
          end else begin
            walking = 1'b1;
            depth   = 2'd0;
            va_held = in_vaddr;
            base    = {root_r, 12'b0};
            walk_results_q.push_back(read_request(levels));
          end
          n_pred++;
        end else if (walking) begin
          // every branch but a plain non-leaf ends the walk
          traversed = {1'b0, depth} + 3'd1;
          xwr       = in_pte_data[3:1];
          next_base = {in_pte_data[53:10], 12'b0};
          walking   = 1'b0;
          if (levels == 3'd0) begin
            walk_results_q.push_back(finished('0, traversed, ST_BAD_MODE, 2'b00));
          end else if (!in_pte_data[0]) begin
            walk_results_q.push_back(finished('0, traversed, ST_INVALID, 2'b00));
          end else if (xwr[1:0] == 2'b10) begin
            walk_results_q.push_back(finished('0, traversed, ST_W_NO_R, 2'b00));
          end else if (xwr != 3'd0) begin
            walk_results_q.push_back(finished(next_base + va_held[11:0], traversed, ST_OK,
                                              in_pte_data[62:61]));
          end else if (in_pte_data[7:6] != 2'b00) begin
            walk_results_q.push_back(finished('0, traversed, ST_NONLEAF_AD, 2'b00));
          end else if (traversed >= levels) begin
            walk_results_q.push_back(finished('0, traversed, ST_NO_LEVELS, 2'b00));
          end else begin
            walking = 1'b1;
            depth   = traversed[1:0];
            base    = next_base;
            walk_results_q.push_back(read_request(levels));
          end
          n_pred++;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:  mode_r  = cfg_wdata[MODE_W-1:0];
          CFG_ROOT:  root_r  = cfg_wdata[PPN_W-1:0];
          CFG_GUEST: guest_r = cfg_wdata[0];
          default: ;
        endcase
      end
    end
    mismatches <= n_fail;
    pending    <= walk_results_q.size();
    predicted  <= n_pred;
  end

endmodule

>>> tb/tb.sv
// testbench top for the page table walker: clock, reset, config writes,
// directed and random translate and pte words, receiver stalls and the verdict
// depends on ptw_pkg, page_table_walker and ptw_checker
`timescale 1ns / 100ps

module tb;
  import ptw_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNSUPPORTED = 4'hF;
  localparam int HOLD_CYCLES = 150;

  typedef enum int {PTE_NEXT, PTE_LEAF, PTE_INVALID, PTE_W_NO_R, PTE_AD, PTE_RAW} pte_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [VADDR_W-1:0]    in_vaddr;
  logic [PTE_W-1:0]      in_pte_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_kind;
  logic [PADDR_W-1:0]    out_address;
  logic [2:0]            out_level;
  logic [2:0]            out_status;
  logic [1:0]            out_pbmt;

  int mismatches;
  int pending;
  int predicted;

  int                send_idle_pct = 31;
  int                recv_idle_pct = 74;
  int                hold_asked = 0;
  int                hold_served = 0;
  int                hold_left = 0;
  logic [MODE_W-1:0] cur_mode = MODE_BARE;

  page_table_walker uut (.*);
  ptw_checker u_check (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off whenever one is asked for
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VADDR_W-1:0] rand_va();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return VADDR_W'(rand64());
    endcase
  endfunction

  function automatic logic [PTE_W-1:0] make_pte(pte_kind_t k);
    logic [PTE_W-1:0] p;
    p = rand64();
    case (k)
      PTE_NEXT: begin
        p[0]   = 1'b1;
        p[3:1] = 3'b000;
        p[7:6] = 2'b00;
      end
      PTE_AD: begin
        p[0]   = 1'b1;
        p[3:1] = 3'b000;
        while (p[7:6] == 2'b00) p[7:6] = 2'($urandom);
      end
      PTE_LEAF: begin
        p[0] = 1'b1;
        while (p[3:1] == 3'b000 || p[2:1] == 2'b10) p[3:1] = 3'($urandom);
      end
      PTE_INVALID: p[0] = 1'b0;
      PTE_W_NO_R: begin
        p[0]   = 1'b1;
        p[2:1] = 2'b10;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_word(input logic op, input logic [VADDR_W-1:0] va,
                           input logic [PTE_W-1:0] pte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_vaddr    <= va;
    in_pte_data <= pte;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and let every expected word drain, plus the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // unused upper bits of the mode and guest writes carry random junk
  task automatic apply_setting(input logic [MODE_W-1:0] mode, input logic [PPN_W-1:0] root,
                               input logic guest);
    logic [CFG_DATA_W-1:0] junk;
    junk     = CFG_DATA_W'(rand64());
    cur_mode = mode;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_wdata <= {junk[CFG_DATA_W-1:MODE_W], mode};
    @(posedge clk);
    cfg_index <= CFG_ROOT;
    cfg_wdata <= root;
    @(posedge clk);
    cfg_index <= CFG_GUEST;
    cfg_wdata <= {junk[CFG_DATA_W-1:1], guest};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int                stage;
    int                phase;
    int                lvl;
    int                levels;
    int                r;
    int                goal;
    pte_kind_t         k;
    logic [MODE_W-1:0] mode;
    logic [PPN_W-1:0]  root;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_MODE;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_op       = OP_TRANSLATE;
    in_vaddr    = '0;
    in_pte_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bare mode after reset passes the address through
    send_word(OP_TRANSLATE, '0, '0);
    send_word(OP_TRANSLATE, '1, '1);
    send_word(OP_PTE_RESP, '1, '1);  // no walk open: dropped

    settle();
    apply_setting(MODE_SV39, '1, 1'b1);
    send_word(OP_TRANSLATE, '1, '0);
    repeat (3) send_word(OP_PTE_RESP, '0, 64'h003F_FFFF_FFFF_FC01);  // last runs out of levels
    send_word(OP_TRANSLATE, '0, '1);
    send_word(OP_PTE_RESP, '1, '0);
    send_word(OP_TRANSLATE, rand_va(), '0);
    send_word(OP_PTE_RESP, '0, 64'h5);   // write without read
    send_word(OP_TRANSLATE, rand_va(), '0);
    send_word(OP_PTE_RESP, '0, 64'hC1);  // pointer with accessed and dirty
    send_word(OP_TRANSLATE, '1, '0);
    send_word(OP_PTE_RESP, '0, '1);      // leaf with every bit set
    send_word(OP_TRANSLATE, rand_va(), '0);
    send_word(OP_TRANSLATE, '1, '0);     // restarts the open walk

    // walk stays open across the mode change
    settle();
    apply_setting(MODE_UNSUPPORTED, '0, 1'b0);
    send_word(OP_PTE_RESP, '0, make_pte(PTE_NEXT));
    send_word(OP_TRANSLATE, '1, '0);

    settle();
    apply_setting(MODE_SV48, '0, 1'b0);
    send_word(OP_TRANSLATE, '1, '0);
    repeat (3) send_word(OP_PTE_RESP, '0, 64'h1);
    send_word(OP_PTE_RESP, '0, 64'h9);  // execute-only leaf at the deepest level

    for (stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct <= 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct <= 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (phase = 0; phase < 4; phase++) begin
        r = $urandom_range(99);
        if (r < 10) begin
          mode = MODE_BARE;
        end else if (r < 18) begin
          do mode = MODE_W'($urandom);
          while (mode == MODE_BARE || mode == MODE_SV39 || mode == MODE_SV48);
        end else if (r < 59) begin
          mode = MODE_SV39;
        end else begin
          mode = MODE_SV48;
        end
        case ($urandom_range(9))
          0:       root = '0;
          1:       root = '1;
          default: root = PPN_W'(rand64());
        endcase
        settle();
        apply_setting(mode, root, 1'($urandom));
        if (phase == 0 && stage != 1) begin
          hold_asked <= hold_asked + 1;
        end
        goal = predicted + 78;
        while (predicted < goal) begin
          if ($urandom_range(99) < 8) begin
            send_word(OP_PTE_RESP, rand_va(), rand64());
          end else begin
            send_word(OP_TRANSLATE, rand_va(), rand64());
            levels = (cur_mode == MODE_SV39) ? 3 : (cur_mode == MODE_SV48) ? 4 : 0;
            for (lvl = 0; lvl < levels; lvl++) begin
              r = $urandom_range(99);
              if (r < 5) break;  // left open: the next request restarts it
              k = (r < 11) ? PTE_INVALID :
                  (r < 17) ? PTE_W_NO_R :
                  (r < 23) ? PTE_AD :
                  (r < 27) ? PTE_RAW :
                  (r < 40 + 12 * lvl) ? PTE_LEAF : PTE_NEXT;
              send_word(OP_PTE_RESP, rand_va(), make_pte(k));
              if (k != PTE_NEXT) break;
            end
          end
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
